@@ sv/tmtd_pkg.sv @@
// Shared types and constants for the tick mask task dispatcher.
// No dependencies; every other file imports this package.
package tmtd_pkg;

    localparam int MAX_TASKS = 16;
    localparam int ID_W      = $clog2(MAX_TASKS);
    localparam int TOTAL_W   = $clog2(MAX_TASKS + 1);
    localparam int PEND_W    = 8;
    localparam int WORD_W    = 32;
    localparam int TASK_ID_W = 8;
    localparam int RUN_W     = 4;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_INIT     = 2'd1,
        OP_ACTIVATE = 2'd2,
        OP_SET_EN   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_DISPATCH = 2'd0,
        KIND_DONE     = 2'd1,
        KIND_ACK      = 2'd2,
        KIND_ERR      = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t                  op;
        logic [TASK_ID_W-1:0] task_id;
        logic [WORD_W-1:0]    match_mask;
        logic [WORD_W-1:0]    match_value;
        logic                 enable_flag;
    } req_t;

    typedef struct packed {
        kind_t              kind;
        logic [RUN_W-1:0]   run_task;
        logic [TOTAL_W-1:0] task_total;
        logic               last;
    } rsp_t;

    // One slot as seen by the match unit during a tick pass.
    typedef struct packed {
        logic              valid;
        logic              enabled;
        logic [PEND_W-1:0] pending;
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] value;
    } slot_view_t;

    // What the match unit hands back for that slot.
    typedef struct packed {
        logic              dispatch;
        logic [PEND_W-1:0] pending;
    } slot_upd_t;

endpackage

@@ sv/tmtd_match_unit.sv @@
// Shared per-slot match and pending-count update used by the tick pass.
// Depends on tmtd_pkg.
module tmtd_match_unit (
    input  logic [tmtd_pkg::WORD_W-1:0] counter,
    input  tmtd_pkg::slot_view_t        slot,
    output tmtd_pkg::slot_upd_t         upd
);
    import tmtd_pkg::*;

    logic              active;
    logic              hit;
    logic [PEND_W-1:0] bumped;

    assign active = slot.valid && slot.enabled;
    assign hit    = (counter & slot.mask) == slot.value;
    // count wraps at 8 bits; a wrap to zero means no dispatch this tick
    assign bumped = hit ? slot.pending + PEND_W'(1) : slot.pending;

    always_comb
    begin
        upd.dispatch = active && (bumped != '0);
        if (!active)
        begin
            upd.pending = slot.pending;
        end
        else if (upd.dispatch)
        begin
            upd.pending = bumped - PEND_W'(1);
        end
        else
        begin
            upd.pending = bumped;
        end
    end

endmodule

@@ sv/tick_mask_task_dispatcher.sv @@
// Top level of the tick mask task dispatcher: handshake, sequencer, slot table.
// Depends on tmtd_pkg and tmtd_match_unit.
//
// Usage: one request beat is taken at a time. Init, activate and set-enable
// requests are captured, then executed once the output register is free, and
// return a single beat flagged last. A tick request bumps the 32-bit tick
// counter and then walks slots 0 up to task_total - 1, one slot per cycle
// unless a dispatch beat waits for the output register, through one shared
// match unit (counter AND mask compared against value, pending count bumped
// and drained). Each dispatched slot returns a dispatch beat; the pass ends
// with a pass-done beat flagged last. The response sits in an output register,
// so a new request is accepted while the final beat of the previous one is
// still waiting for rsp_ready. Errors: init with task_id >= MAX_TASKS,
// activate with task_id >= task_total, and set-enable on a slot that was
// never initialized. Mask and value storage has no reset; it is only read for
// slots marked valid, which init writes together with the mask and value.
module tick_mask_task_dispatcher (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  tmtd_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output tmtd_pkg::rsp_t   rsp
);
    import tmtd_pkg::*;

    // sequencer and captured request
    state_t              state_reg, state_next;
    req_t                item_reg, item_next;
    logic [TOTAL_W-1:0]  idx_reg, idx_next;

    // architectural state
    logic [WORD_W-1:0]    counter_reg, counter_next;
    logic [TOTAL_W-1:0]   slots_reg, slots_next;
    logic [MAX_TASKS-1:0] valid_reg, valid_next;
    logic [MAX_TASKS-1:0] enabled_reg, enabled_next;
    logic [PEND_W-1:0]    pend_reg [MAX_TASKS];
    logic [PEND_W-1:0]    pend_next [MAX_TASKS];
    logic [WORD_W-1:0]    mask_reg [MAX_TASKS];
    logic [WORD_W-1:0]    value_reg [MAX_TASKS];

    // output register
    logic out_valid_reg, out_valid_next;
    rsp_t out_reg, out_next;

    // init write strobe into the mask/value table
    logic              tbl_we;
    logic [ID_W-1:0]   item_sid;
    logic [ID_W-1:0]   scan_sid;
    logic              out_free;
    logic              id_in_range;
    logic              id_below_used;
    logic [TOTAL_W-1:0] id_plus_one;

    slot_view_t scan_slot;
    slot_upd_t  scan_upd;

    assign item_sid      = item_reg.task_id[ID_W-1:0];
    assign scan_sid      = idx_reg[ID_W-1:0];
    assign out_free      = !out_valid_reg || rsp_ready;
    assign id_in_range   = item_reg.task_id < TASK_ID_W'(MAX_TASKS);
    assign id_below_used = item_reg.task_id < TASK_ID_W'(slots_reg);
    assign id_plus_one   = TOTAL_W'(item_sid) + TOTAL_W'(1);

    assign scan_slot.valid   = valid_reg[scan_sid];
    assign scan_slot.enabled = enabled_reg[scan_sid];
    assign scan_slot.pending = pend_reg[scan_sid];
    assign scan_slot.mask    = mask_reg[scan_sid];
    assign scan_slot.value   = value_reg[scan_sid];

    tmtd_match_unit u_match (
        .counter (counter_reg),
        .slot    (scan_slot),
        .upd     (scan_upd)
    );

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        idx_next       = idx_reg;
        counter_next   = counter_reg;
        slots_next     = slots_reg;
        valid_next     = valid_reg;
        enabled_next   = enabled_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_next       = out_reg;
        tbl_we         = 1'b0;
        req_ready      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    item_next = req;
                    if (req.op == OP_TICK)
                    begin
                        counter_next = counter_reg + WORD_W'(1);
                        idx_next     = '0;
                        state_next   = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_EXEC:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.kind       = KIND_ERR;
                    out_next.run_task   = '0;
                    out_next.task_total = slots_reg;
                    out_next.last       = 1'b1;
                    unique case (item_reg.op)
                        OP_INIT:
                        begin
                            if (id_in_range)
                            begin
                                tbl_we                 = 1'b1;
                                valid_next[item_sid]   = 1'b1;
                                enabled_next[item_sid] = 1'b1;
                                pend_next[item_sid]    = '0;
                                if (id_plus_one > slots_reg)
                                begin
                                    slots_next          = id_plus_one;
                                    out_next.task_total = id_plus_one;
                                end
                                out_next.kind     = KIND_ACK;
                                out_next.run_task = RUN_W'(item_sid);
                            end
                        end
                        OP_ACTIVATE:
                        begin
                            if (id_below_used)
                            begin
                                pend_next[item_sid] = pend_reg[item_sid] + PEND_W'(1);
                                out_next.kind       = KIND_ACK;
                                out_next.run_task   = RUN_W'(item_sid);
                            end
                        end
                        OP_SET_EN:
                        begin
                            if (id_in_range && valid_reg[item_sid])
                            begin
                                enabled_next[item_sid] = item_reg.enable_flag;
                                out_next.kind          = KIND_ACK;
                                out_next.run_task      = RUN_W'(item_sid);
                            end
                        end
                        OP_TICK:
                        begin
                            // ticks never land here; error beat keeps the
                            // handshake moving regardless
                        end
                    endcase
                    state_next = ST_IDLE;
                end
            end

            ST_SCAN:
            begin
                if (idx_reg >= slots_reg)
                begin
                    state_next = ST_DONE;
                end
                else if (scan_upd.dispatch)
                begin
                    // hold the slot until the dispatch beat has a place
                    if (out_free)
                    begin
                        pend_next[scan_sid] = scan_upd.pending;
                        out_valid_next      = 1'b1;
                        out_next.kind       = KIND_DISPATCH;
                        out_next.run_task   = RUN_W'(scan_sid);
                        out_next.task_total = slots_reg;
                        out_next.last       = 1'b0;
                        idx_next            = idx_reg + TOTAL_W'(1);
                    end
                end
                else
                begin
                    pend_next[scan_sid] = scan_upd.pending;
                    idx_next            = idx_reg + TOTAL_W'(1);
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next      = 1'b1;
                    out_next.kind       = KIND_DONE;
                    out_next.run_task   = '0;
                    out_next.task_total = slots_reg;
                    out_next.last       = 1'b1;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            counter_reg   <= '0;
            slots_reg     <= '0;
            valid_reg     <= '0;
            enabled_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                pend_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            counter_reg   <= counter_next;
            slots_reg     <= slots_next;
            valid_reg     <= valid_next;
            enabled_reg   <= enabled_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        out_reg  <= out_next;
        if (tbl_we)
        begin
            mask_reg[item_sid]  <= item_reg.match_mask;
            value_reg[item_sid] <= item_reg.match_value;
        end
    end

endmodule

@@ verif/tick_mask_task_dispatcher_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for tick_mask_task_dispatcher: directed and random request beats,
// an in-bench slot table that predicts every response beat, and random stalls on both sides.
// Depends on tmtd_pkg and the tick_mask_task_dispatcher RTL.
module tick_mask_task_dispatcher_tb;
    import tmtd_pkg::*;

    // Cycles with no beat on either channel before the run is declared hung.
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 60;
    localparam int DRAIN_CYCLES = MAX_TASKS + 8;
    localparam int MAX_REPORTS  = 10;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    tick_mask_task_dispatcher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Request beats waiting to be driven, and response beats the table says are owed.
    req_t req_backlog[$];
    rsp_t due_beats[$];

    int total_items;
    int sent_count;
    int accepted_count;
    int stall_cycles;
    int error_count;
    logic req_taken;

    // Shadow of the slot table.
    logic [WORD_W-1:0]  tick_count;
    logic [TOTAL_W-1:0] slots_in_use;
    logic               slot_valid   [MAX_TASKS];
    logic               slot_enabled [MAX_TASKS];
    logic [PEND_W-1:0]  slot_pending [MAX_TASKS];
    logic [WORD_W-1:0]  slot_mask    [MAX_TASKS];
    logic [WORD_W-1:0]  slot_value   [MAX_TASKS];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall phases follow the share of beats sent so far: sender light / receiver heavy,
    // then swapped, then no stalls at all.
    function automatic int load_phase();
        if (total_items == 0)
            return 0;
        return (sent_count * 3) / total_items;
    endfunction

    function automatic int tx_idle_pct();
        case (load_phase())
            0: return 23;
            1: return 87;
            default: return 0;
        endcase
    endfunction

    function automatic int rx_idle_pct();
        case (load_phase())
            0: return 87;
            1: return 23;
            default: return 0;
        endcase
    endfunction

    task automatic queue_req(input op_t op, input int id, input logic [WORD_W-1:0] m,
                             input logic [WORD_W-1:0] v, input logic en);
        req_t r;
        r.op          = op;
        r.task_id     = id[TASK_ID_W-1:0];
        r.match_mask  = m;
        r.match_value = v;
        r.enable_flag = en;
        req_backlog.push_back(r);
    endtask

    // task_total always reports the slot count after the request took effect.
    task automatic push_beat(input kind_t k, input logic [RUN_W-1:0] slot, input logic fin);
        rsp_t b;
        b.kind       = k;
        b.run_task   = slot;
        b.task_total = slots_in_use;
        b.last       = fin;
        due_beats.push_back(b);
    endtask

    // Applies one accepted request to the shadow table and queues the beats it owes.
    task automatic apply_to_table(input req_t r);
        int id;
        id = int'(r.task_id);
        case (r.op)
            OP_TICK:
            begin
                tick_count = tick_count + 1'b1;
                for (int i = 0; i < slots_in_use; i++)
                begin
                    if (slot_valid[i] && slot_enabled[i])
                    begin
                        // a match at 255 wraps to zero, so no dispatch that tick
                        if ((tick_count & slot_mask[i]) == slot_value[i])
                            slot_pending[i] = slot_pending[i] + 1'b1;
                        if (slot_pending[i] != '0)
                        begin
                            slot_pending[i] = slot_pending[i] - 1'b1;
                            push_beat(KIND_DISPATCH, i[RUN_W-1:0], 1'b0);
                        end
                    end
                end
                push_beat(KIND_DONE, '0, 1'b1);
            end
            OP_INIT:
            begin
                if (id >= MAX_TASKS)
                    push_beat(KIND_ERR, '0, 1'b1);
                else
                begin
                    slot_valid[id]   = 1'b1;
                    slot_enabled[id] = 1'b1;
                    slot_pending[id] = '0;
                    slot_mask[id]    = r.match_mask;
                    slot_value[id]   = r.match_value;
                    if (id >= slots_in_use)
                        slots_in_use = TOTAL_W'(id + 1);
                    push_beat(KIND_ACK, id[RUN_W-1:0], 1'b1);
                end
            end
            OP_ACTIVATE:
            begin
                // counts even on a slot never set up; a tick skips it until init clears it
                if (id >= slots_in_use)
                    push_beat(KIND_ERR, '0, 1'b1);
                else
                begin
                    slot_pending[id] = slot_pending[id] + 1'b1;
                    push_beat(KIND_ACK, id[RUN_W-1:0], 1'b1);
                end
            end
            default:
            begin
                if (id >= MAX_TASKS || !slot_valid[id])
                    push_beat(KIND_ERR, '0, 1'b1);
                else
                begin
                    slot_enabled[id] = r.enable_flag;
                    push_beat(KIND_ACK, id[RUN_W-1:0], 1'b1);
                end
            end
        endcase
    endtask

    // Driver: moves on at the falling edge once the held beat was taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!req_valid || req_taken)
            begin
                if (req_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct())
                begin
                    req        <= req_backlog.pop_front();
                    req_valid  <= 1'b1;
                    sent_count <= sent_count + 1;
                end
                else
                    req_valid <= 1'b0;
            end
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct());
        end
    end

    // Monitor: samples both channels at the rising edge. Responses are checked before
    // the new request is predicted, since a beat seen now always belongs to an older one.
    always @(posedge clk)
    begin
        req_taken = 1'b0;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (due_beats.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("unexpected beat: kind %0d run_task %0d task_total %0d last %0d",
                                 rsp.kind, rsp.run_task, rsp.task_total, rsp.last);
                end
                else
                begin
                    rsp_t want;
                    want = due_beats.pop_front();
                    if (rsp.kind !== want.kind || rsp.run_task !== want.run_task ||
                        rsp.task_total !== want.task_total || rsp.last !== want.last)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display({"mismatch: want kind %0d run_task %0d total %0d last %0d,",
                                      " got kind %0d run_task %0d total %0d last %0d"},
                                     want.kind, want.run_task, want.task_total, want.last,
                                     rsp.kind, rsp.run_task, rsp.task_total, rsp.last);
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                apply_to_table(req);
                req_taken = 1'b1;
                accepted_count++;
            end
            if ((rsp_valid && rsp_ready) || (req_valid && req_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    initial
    begin
        int roll;
        int sel;
        int k;
        int id;
        logic [WORD_W-1:0] m;
        logic [WORD_W-1:0] v;

        rst_n          = 1'b0;
        req_valid      = 1'b0;
        rsp_ready      = 1'b0;
        req            = '0;
        req_taken      = 1'b0;
        total_items    = 0;
        sent_count     = 0;
        accepted_count = 0;
        stall_cycles   = 0;
        error_count    = 0;
        tick_count     = '0;
        slots_in_use   = '0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            slot_valid[i]   = 1'b0;
            slot_enabled[i] = 1'b0;
            slot_pending[i] = '0;
            slot_mask[i]    = '0;
            slot_value[i]   = '0;
        end

        // --- directed ---
        queue_req(OP_TICK, 0, '0, '0, 1'b0);           // empty table: pass-done only
        queue_req(OP_ACTIVATE, 0, '0, '0, 1'b0);       // nothing in use yet
        queue_req(OP_SET_EN, 0, '0, '0, 1'b1);         // slot never set up
        queue_req(OP_INIT, MAX_TASKS, '0, '0, 1'b0);   // just past the table
        queue_req(OP_INIT, 255, '1, '1, 1'b1);
        queue_req(OP_INIT, MAX_TASKS - 1, '0, '0, 1'b0); // top slot, matches every tick
        queue_req(OP_ACTIVATE, 3, '0, '0, 1'b0);       // in range but never set up
        queue_req(OP_TICK, 255, '1, '1, 1'b1);
        queue_req(OP_INIT, 0, '1, '1, 1'b0);
        queue_req(OP_INIT, 1, '0, 32'd1, 1'b0);        // never matches, drains activations
        queue_req(OP_ACTIVATE, 1, '0, '0, 1'b0);
        queue_req(OP_ACTIVATE, 1, '0, '0, 1'b0);
        queue_req(OP_TICK, 0, '0, '0, 1'b0);
        queue_req(OP_SET_EN, MAX_TASKS - 1, '1, '1, 1'b0);
        queue_req(OP_TICK, 0, '0, '0, 1'b0);
        queue_req(OP_TICK, 0, '0, '0, 1'b0);
        queue_req(OP_SET_EN, MAX_TASKS - 1, '0, '0, 1'b1);
        queue_req(OP_ACTIVATE, MAX_TASKS, '0, '0, 1'b0);
        queue_req(OP_ACTIVATE, 255, '1, '1, 1'b1);
        queue_req(OP_SET_EN, 200, '0, '0, 1'b1);
        queue_req(OP_SET_EN, MAX_TASKS, '0, '0, 1'b0);
        queue_req(OP_INIT, 3, 32'd3, 32'd2, 1'b0);     // every fourth tick; clears its count

        // pending wrap: park slot 2 disabled, push it to 255, then let a match wrap it
        queue_req(OP_INIT, 2, '0, '0, 1'b0);
        queue_req(OP_SET_EN, 2, '0, '0, 1'b0);
        for (int i = 0; i < 255; i++)
            queue_req(OP_ACTIVATE, 2, $urandom, $urandom, $urandom_range(1));
        queue_req(OP_SET_EN, 2, '0, '0, 1'b1);
        queue_req(OP_TICK, 0, '0, '0, 1'b0);
        queue_req(OP_TICK, 0, '0, '0, 1'b0);

        // --- random ---
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            roll = $urandom_range(99);
            id   = ($urandom_range(99) < 85) ? $urandom_range(MAX_TASKS) : $urandom_range(255);
            if (roll < 35)
                queue_req(OP_TICK, $urandom_range(255), $urandom, $urandom, $urandom_range(1));
            else if (roll < 55)
            begin
                sel = $urandom_range(99);
                if (sel < 50)
                begin
                    // short period: these fire often
                    k = $urandom_range(4);
                    m = (32'd1 << k) - 1;
                    v = $urandom & m;
                end
                else if (sel < 70)
                begin
                    m = $urandom;
                    v = $urandom & m;
                end
                else if (sel < 85)
                begin
                    m = $urandom;
                    v = $urandom;
                end
                else
                begin
                    m = $urandom_range(1) ? '1 : '0;
                    v = $urandom_range(1) ? '1 : '0;
                end
                queue_req(OP_INIT, id, m, v, $urandom_range(1));
            end
            else if (roll < 75)
                queue_req(OP_ACTIVATE, id, $urandom, $urandom, $urandom_range(1));
            else if (roll < 92)
                queue_req(OP_SET_EN, id, $urandom, $urandom,
                          ($urandom_range(99) < 70) ? 1'b1 : 1'b0);
            else
            begin
                // burst of activations on one slot, then ticks to drain it
                k = $urandom_range(6, 1);
                for (int j = 0; j < k; j++)
                    queue_req(OP_ACTIVATE, id % MAX_TASKS, $urandom, $urandom, 1'b0);
                for (int j = 0; j < 3; j++)
                    queue_req(OP_TICK, 0, $urandom, $urandom, 1'b1);
            end
        end
        total_items = req_backlog.size();

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        while (!(accepted_count == total_items && due_beats.size() == 0) &&
               stall_cycles < STALL_LIMIT)
            @(negedge clk);

        if (stall_cycles >= STALL_LIMIT)
            $display("tick_mask_task_dispatcher_tb: done, errors");
        else
        begin
            // let any stray beat show up before judging
            repeat (DRAIN_CYCLES) @(negedge clk);
            if (error_count == 0 && due_beats.size() == 0)
                $display("tick_mask_task_dispatcher_tb: done, clean");
            else
                $display("tick_mask_task_dispatcher_tb: done, errors");
        end
        $finish;
    end

endmodule
